>>> sv/vcn_pkg.sv
// Package: shared constants and types for the vector center normalize block.
package vcn_pkg;
   localparam int MAX_LEN = 64;
   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = 53;
   localparam int ROOT_W = 32;
   localparam int NUM_W = 50;
   localparam logic [0:0] CSR_VEC_LEN = 1'd0;
   localparam logic [0:0] CSR_OFFSET = 1'd1;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [23:0] UNIT_ONE = 24'd4194304;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
   } vec_job_type;
endpackage

>>> sv/vcn_front.sv
// Front end: centers, saturates, stores elements, accumulates squares, issues vector jobs.
module vcn_front import vcn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic signed [23:0] req_element,
   input  logic [6:0]        vec_len,
   input  logic signed [23:0] centre_offset,
   output logic              job_valid,
   output vec_job_type       job,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic signed [23:0] rd_data
);
   logic signed [23:0] store [MAX_LEN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic signed [24:0] diff;
   logic signed [23:0] d;
   logic [23:0] mag;
   logic [47:0] sq;
   logic [SUM_W:0] acc;
   logic [CNT_W-1:0] eff_len;
   logic accept;

   assign accept = start && !busy;
   assign diff = 25'(req_element) - 25'(centre_offset);

   always_comb begin
      if (diff > 25'sd8388607) d = 24'sh7FFFFF;
      else if (diff < -25'sd8388608) d = 24'sh800000;
      else d = diff[23:0];
      mag = d[23] ? 24'(-d) : 24'(d);
      if (d == 24'sh800000) mag = 24'h800000;
      sq = mag * mag;
      acc = {1'b0, sum_ff} + {6'd0, sq};
      if (vec_len == 7'd0) eff_len = CNT_W'(1);
      else if (vec_len > 7'(MAX_LEN)) eff_len = CNT_W'(MAX_LEN);
      else eff_len = CNT_W'(vec_len);
   end

   logic [CNT_W-1:0] new_count;
   assign new_count = (count_ff < CNT_W'(MAX_LEN)) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      job_valid = 1'b0;
      job.count = new_count;
      job.sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      if (accept) begin
         if (new_count >= eff_len) begin
            job_valid = 1'b1;
            count_in = '0;
            sum_in = '0;
         end else begin
            count_in = new_count;
            sum_in = job.sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && count_ff < CNT_W'(MAX_LEN)) store[count_ff[IDX_W-1:0]] <= d;
      rd_data <= store[rd_addr];
      if (reset) begin
         count_ff <= '0;
         sum_ff <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff <= sum_in;
      end
   end
endmodule

>>> sv/vcn_back.sv
// Back end: iterative square root, then one iterative divide per stored element.
module vcn_back import vcn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  vec_job_type       job,
   output logic              back_busy,
   output logic [IDX_W-1:0]  rd_addr,
   input  logic signed [23:0] rd_data,
   output logic              rsp_valid,
   output logic signed [23:0] rsp_unit_element,
   output logic              rsp_last
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQRT = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [61:0] rad_ff, rad_in;
   logic [61:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [5:0] step_ff, step_in;
   logic [CNT_W-1:0] n_ff, n_in, k_ff, k_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [ROOT_W:0] drem_ff, drem_in;
   logic neg_ff, neg_in;
   logic [63:0] trial;
   logic [ROOT_W+1:0] dtrial;
   logic [23:0] m;
   logic [NUM_W-1:0] num0;
   logic [ROOT_W-1:0] qv;
   logic [23:0] u;

   assign back_busy = state_ff != ST_IDLE;
   assign rd_addr = k_ff[IDX_W-1:0];

   always_comb begin
      state_in = state_ff; rad_in = rad_ff; rem_in = rem_ff; root_in = root_ff;
      step_in = step_ff; n_in = n_ff; k_in = k_ff; num_in = num_ff;
      drem_in = drem_ff; neg_in = neg_ff;
      rsp_valid = 1'b0; rsp_unit_element = '0; rsp_last = 1'b0;
      trial = '0; dtrial = '0; m = '0; num0 = '0; qv = '0; u = '0;
      unique case (state_ff)
         ST_IDLE: if (job_valid) begin
            rad_in = {1'b0, job.sum, 8'd0};
            rem_in = '0; root_in = '0; step_in = '0;
            n_in = job.count; k_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // restoring root: two radicand bits per step
            trial = {rem_ff, rad_ff[61:60]} - {30'd0, root_ff, 2'b01};
            rad_in = {rad_ff[59:0], 2'b00};
            if (!trial[63] || ({rem_ff, rad_ff[61:60]} >= {30'd0, root_ff, 2'b01})) begin
               rem_in = trial[61:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[59:0], rad_ff[61:60]};
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd30) state_in = ST_READ;
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            m = rd_data[23] ? 24'(-rd_data) : 24'(rd_data);
            num0 = {m, 26'd0} + NUM_W'(root_ff >> 1);
            num_in = num0; drem_in = '0; step_in = '0;
            neg_in = rd_data[23];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dtrial = {drem_ff, num_ff[NUM_W-1]} - {2'b00, root_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (!dtrial[ROOT_W+1]) begin
               drem_in = dtrial[ROOT_W:0]; num_in[0] = 1'b1;
            end else drem_in = {drem_ff[ROOT_W-1:0], num_ff[NUM_W-1]};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(NUM_W - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            qv = num_ff[ROOT_W-1:0];
            if (root_ff == '0) u = '0;
            else if (num_ff[NUM_W-1:23] != '0) u = UNIT_ONE;
            else u = (qv > 32'(UNIT_ONE)) ? UNIT_ONE : qv[23:0];
            rsp_valid = 1'b1;
            rsp_unit_element = neg_ff ? 24'(-u) : u;
            rsp_last = (k_ff + 1'b1) == n_ff;
            k_in = k_ff + 1'b1;
            state_in = rsp_last ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in; rem_ff <= rem_in; root_ff <= root_in; step_ff <= step_in;
      n_ff <= n_in; k_ff <= k_in; num_ff <= num_in; drem_ff <= drem_in; neg_ff <= neg_in;
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

>>> sv/vector_center_normalize_top.sv
// Top level of the vector center normalize block.
// Usage: pulse start with req_element while busy is low to send one element transaction.
// Config: csr_we/csr_index/csr_wdata write vec_len (index 0) or centre_offset (index 1),
// only while idle (a rule for the user; the block does not enforce it). Elements are
// centered, saturated and stored; squares accumulate. When vec_len elements are held
// (0 counts as 1, above 64 as 64), the vector passes to the back end and busy rises.
// The back end runs a 31-step square root, then for each element a read, load, 50-step
// divide and output state: rsp_valid strobes unit_element with rsp_last on the final
// element. Throughput is set by the bit-serial divider; no new element is taken while
// busy. busy stays high until the last result has been shown.
// Results are shown for one cycle only; the receiver cannot stall.
// Reset (synchronous, active high) clears counts, sums and config to defaults.
module vector_center_normalize_top import vcn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [23:0] req_element,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   output logic              rsp_valid,
   output logic signed [23:0] rsp_unit_element,
   output logic              rsp_last
);
   logic [6:0] vec_len_ff;
   logic signed [23:0] offset_ff;
   logic job_valid, back_busy;
   vec_job_type job;
   logic [IDX_W-1:0] rd_addr;
   logic signed [23:0] rd_data;

   assign busy = back_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_len_ff <= 7'd8;
         offset_ff <= '0;
      end else if (csr_we && csr_index[1] == 1'b0) begin
         if (csr_index[0] == CSR_VEC_LEN) vec_len_ff <= csr_wdata[6:0];
         else offset_ff <= csr_wdata;
      end
   end

   vcn_front u_front (
      .clock, .reset, .start, .busy,
      .req_element, .vec_len(vec_len_ff), .centre_offset(offset_ff),
      .job_valid, .job, .rd_addr, .rd_data
   );

   vcn_back u_back (
      .clock, .reset, .job_valid, .job, .back_busy, .rd_addr, .rd_data,
      .rsp_valid, .rsp_unit_element, .rsp_last
   );
endmodule

>>> sv/vcn_checker.sv
// Port checker for the vector center normalize block.
module vcn_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last
);
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without valid");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");
   a_last_free: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !busy) else $error("busy after last");
endmodule

bind vector_center_normalize_top vcn_checker u_vcn_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last(rsp_last)
);

>>> bench/tb.sv
// Testbench for vector_center_normalize_top: random and directed vectors, self-checking.
module tb;
   import vcn_pkg::*;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam int TARGET_ELEMS = 470;

   typedef enum logic [1:0] {OP_ELEM, OP_CSR, OP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    idx;
      logic [23:0]   data;
   } step_type;

   typedef struct {
      logic signed [23:0] unit;
      logic               last;
   } unit_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic signed [23:0] req_element = '0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [23:0]       csr_wdata = '0;
   logic              rsp_valid;
   logic signed [23:0] rsp_unit_element;
   logic              rsp_last;

   step_type        pend_q[$];
   unit_result_type unit_q[$];

   // predictor state
   logic [6:0]         vlen;
   logic signed [23:0] offset;
   logic signed [23:0] held[MAX_LEN];
   logic [63:0]        sq_sum;
   int                 held_cnt;

   int  err_cnt = 0;
   int  n_elem = 0;
   int  n_res = 0;
   int  n_csr = 0;
   int  n_vec = 0;
   int  gen_elems = 0;
   int  gap_left = 0;
   int  settle = 0;
   bit  elem_taken = 0;
   int  gen_off = 0;

   vector_center_normalize_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_element      (req_element),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_unit_element (rsp_unit_element),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void normalize_accept(logic signed [23:0] el);
      longint          dd;
      longint          mag;
      logic [63:0]     sq;
      logic [63:0]     r;
      logic [63:0]     u;
      int              eff;
      unit_result_type res;
      dd = longint'(el) - longint'(offset);
      if (dd > 8388607) dd = 8388607;
      if (dd < -8388608) dd = -8388608;
      if (held_cnt < MAX_LEN) begin
         held[held_cnt] = dd[23:0];
         held_cnt++;
      end
      mag = (dd < 0) ? -dd : dd;
      sq = 64'(mag * mag);
      if (sq_sum > 64'(SUM_MAX) - sq) sq_sum = 64'(SUM_MAX);
      else sq_sum = sq_sum + sq;
      eff = (vlen == 0) ? 1 : ((vlen > MAX_LEN) ? MAX_LEN : int'(vlen));
      if (held_cnt < eff) return;
      r = (sq_sum == 0) ? 64'd0 : root_floor(sq_sum << 8);
      for (int k = 0; k < held_cnt; k++) begin
         res.unit = '0;
         if (r != 0) begin
            mag = (held[k] < 0) ? -longint'(held[k]) : longint'(held[k]);
            u = ((64'(mag) << 26) + (r >> 1)) / r;
            if (u > 64'(UNIT_ONE)) u = 64'(UNIT_ONE);
            res.unit = (held[k] < 0) ? -u[23:0] : u[23:0];
         end
         res.last = (k + 1 == held_cnt);
         unit_q.push_back(res);
      end
      n_vec++;
      held_cnt = 0;
      sq_sum = 0;
   endfunction

   // monitor and predictor
   always @(posedge clock) begin
      unit_result_type ex;
      if (reset) begin
         vlen = 7'd8;
         offset = '0;
         sq_sum = 0;
         held_cnt = 0;
      end else begin
         if (rsp_valid) begin
            n_res++;
            if (unit_q.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected result unit=%0d last=%0b", $time,
                        rsp_unit_element, rsp_last);
            end else begin
               ex = unit_q.pop_front();
               if (rsp_unit_element !== ex.unit) begin
                  err_cnt++;
                  $display("%0t: unit_element expected %0d actual %0d", $time,
                           ex.unit, rsp_unit_element);
               end
               if (rsp_last !== ex.last) begin
                  err_cnt++;
                  $display("%0t: last expected %0b actual %0b", $time, ex.last, rsp_last);
               end
            end
         end
         if (csr_we) begin
            n_csr++;
            case (csr_index)
               CSR_VEC_LEN: vlen = csr_wdata[6:0];
               CSR_OFFSET:  offset = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            n_elem++;
            elem_taken = 1;
            normalize_accept(req_element);
         end
      end
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 0;
      if (sel < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(negedge clock) begin
      step_type s;
      logic  nstart;
      logic  nwe;
      nstart = 1'b0;
      nwe = 1'b0;
      if (reset) begin
         gap_left = 0;
         settle = 0;
      end else if (start && !elem_taken) begin
         nstart = 1'b1;
      end else begin
         elem_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pend_q.size() > 0) begin
            s = pend_q[0];
            case (s.kind)
               OP_ELEM: begin
                  void'(pend_q.pop_front());
                  req_element <= s.data;
                  nstart = 1'b1;
                  gap_left = pick_gap();
               end
               OP_CSR: begin
                  void'(pend_q.pop_front());
                  csr_index <= s.idx;
                  csr_wdata <= s.data;
                  nwe = 1'b1;
               end
               default: begin
                  if (unit_q.size() == 0 && !busy) begin
                     if (settle >= 8) begin
                        void'(pend_q.pop_front());
                        settle = 0;
                     end else begin
                        settle++;
                     end
                  end else begin
                     settle = 0;
                  end
               end
            endcase
         end
      end
      start <= nstart;
      csr_we <= nwe;
   end

   task automatic push_elem(int v);
      step_type s;
      s.kind = OP_ELEM;
      s.idx = '0;
      s.data = 24'(v);
      pend_q.push_back(s);
      gen_elems++;
   endtask

   task automatic push_csr(logic [1:0] idx, int v);
      step_type s;
      s.kind = OP_CSR;
      s.idx = idx;
      s.data = 24'(v);
      pend_q.push_back(s);
   endtask

   task automatic push_drain();
      step_type s;
      s.kind = OP_DRAIN;
      s.idx = '0;
      s.data = '0;
      pend_q.push_back(s);
   endtask

   function automatic int gen_element(int mode);
      case (mode)
         0: return int'($urandom_range(0, 24'hFFFFFF));
         1: return gen_off + int'($urandom_range(0, 65536)) - 32768;
         2: return gen_off;
         default: return ($urandom_range(0, 1) == 1) ? 8388607 : -8388608;
      endcase
   endfunction

   initial begin
      int sel;
      int eff;
      int nvec;
      int mode;
      int lv;
      int ntail;
      // directed: extremes with default length 8
      push_elem(8388607); push_elem(-8388608); push_elem(0); push_elem(1);
      push_elem(-1); push_elem(4096); push_elem(-4096); push_elem(8388607);
      // positive saturation of the difference
      push_drain();
      push_csr(CSR_OFFSET, -8388608);
      push_csr(CSR_VEC_LEN, 2);
      push_elem(8388607); push_elem(0);
      // negative saturation
      push_drain();
      push_csr(CSR_OFFSET, 8388607);
      push_csr(CSR_VEC_LEN, 1);
      push_elem(-8388608);
      // spare indexes ignored, zero length treated as one, zero sum
      push_drain();
      push_csr(CSR_OFFSET, 0);
      push_csr(CSR_SPARE_A, 5);
      push_csr(CSR_SPARE_B, 24'hFFFFFF);
      push_csr(CSR_VEC_LEN, 0);
      push_elem(0); push_elem(12345);
      // zero sum over several elements
      push_drain();
      push_csr(CSR_OFFSET, 4096);
      push_csr(CSR_VEC_LEN, 2);
      push_elem(4096); push_elem(4096);
      // length lowered mid-vector
      push_drain();
      push_csr(CSR_OFFSET, 0);
      push_csr(CSR_VEC_LEN, 3);
      push_elem(100); push_elem(-100);
      push_drain();
      push_csr(CSR_VEC_LEN, 1);
      push_elem(7);

      while (gen_elems < TARGET_ELEMS) begin
         push_drain();
         sel = $urandom_range(0, 19);
         if (sel == 0) lv = 0;
         else if (sel == 1) lv = 127;
         else if (sel == 2) lv = 64;
         else if (sel == 3) lv = $urandom_range(65, 126);
         else lv = $urandom_range(1, 8);
         eff = (lv == 0) ? 1 : ((lv > MAX_LEN) ? MAX_LEN : lv);
         push_csr(CSR_VEC_LEN, lv);
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 3) == 0) gen_off = int'($urandom_range(0, 24'hFFFFFF));
            else gen_off = int'($urandom_range(0, 16384)) - 8192;
            gen_off = int'(24'(gen_off)) << 8 >>> 8;
            push_csr(CSR_OFFSET, gen_off);
         end
         if ($urandom_range(0, 7) == 0)
            push_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                     int'($urandom_range(0, 24'hFFFFFF)));
         nvec = (eff > 8) ? 1 : $urandom_range(1, 4);
         for (int v = 0; v < nvec; v++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
            for (int k = 0; k < eff; k++) push_elem(gen_element(mode));
         end
         if (eff > 1 && $urandom_range(0, 3) == 0) begin
            ntail = $urandom_range(1, eff - 1);
            for (int k = 0; k < ntail; k++) push_elem(gen_element(0));
         end
      end

      while (pend_q.size() != 0 || start || csr_we) @(posedge clock);
      while (unit_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("tb: %0d elements, %0d vectors, %0d results, %0d register writes",
               n_elem, n_vec, n_res, n_csr);
      $display("tb: lengths 0..127, offsets incl. extremes, saturation and zero sums covered");
      if (err_cnt == 0 && unit_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end
endmodule

>>> filelist.f
sv/vcn_pkg.sv
sv/vcn_front.sv
sv/vcn_back.sv
sv/vector_center_normalize_top.sv
sv/vcn_checker.sv
bench/tb.sv
